### hdl/rlemj_pkg.sv
// ----------------------------------------------------------------------------
// rlemj_pkg
// Shared constants, codes and transaction types of the RLE merge-join probe.
// ----------------------------------------------------------------------------
package rlemj_pkg;

   localparam int RUN_SLOTS   = 1024;
   localparam int ORDER_SLOTS = 4096;
   localparam int MAX_RUN     = 64;

   localparam int KEY_W    = 32;
   localparam int LEN_W    = 7;
   localparam int RUN_AW   = $clog2(RUN_SLOTS);
   localparam int RUN_CW   = $clog2(RUN_SLOTS + 1);
   localparam int ORDER_AW = $clog2(ORDER_SLOTS);
   localparam int ORDER_CW = $clog2(ORDER_SLOTS + 1);

   localparam logic [1:0] OP_LOAD_RUN   = 2'd0;
   localparam logic [1:0] OP_LOAD_ORDER = 2'd1;
   localparam logic [1:0] OP_PROBE      = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [KEY_W-1:0] key_value;
      logic [LEN_W-1:0] run_length;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] customer_key;
      logic [KEY_W-1:0] order_key;
      logic             last_row;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic run_rd;
      logic finish_run;
      logic row_rd;
      logic row_emit;
      logic row_next;
   } rlemj_cmd_type;

   typedef struct packed {
      logic runs_left;
      logic key_gt;
      logic key_eq;
      logic rl_zero;
      logic row_last;
      logic rsp_free;
   } rlemj_status_type;

endpackage

### hdl/rlemj_datapath.sv
// ----------------------------------------------------------------------------
// rlemj_datapath
// Run and order-key stores, load counters, cursors and the result register.
// ----------------------------------------------------------------------------
module rlemj_datapath
   import rlemj_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_payload,
   input  rlemj_cmd_type    cmd,
   output rlemj_status_type status,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output rsp_type          rsp_payload
);

   logic [KEY_W+LEN_W-1:0] run_mem [RUN_SLOTS];
   logic [KEY_W-1:0]       order_mem [ORDER_SLOTS];

   logic [RUN_CW-1:0]      runs_loaded_ff, runs_loaded_in;
   logic [ORDER_CW-1:0]    orders_loaded_ff, orders_loaded_in;
   logic [RUN_CW-1:0]      run_cursor_ff, run_cursor_in;
   logic [ORDER_CW-1:0]    order_cursor_ff, order_cursor_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [KEY_W-1:0]       key_ff;
   logic [KEY_W+LEN_W-1:0] run_rdata_ff;
   logic [KEY_W-1:0]       order_rdata_ff;
   logic                   in_range_ff;
   logic [LEN_W-1:0]       row_idx_ff;
   rsp_type                rsp_ff;

   logic                   load_run, load_order;
   logic [LEN_W-1:0]       len_clamped;
   logic [KEY_W-1:0]       run_val;
   logic [LEN_W-1:0]       run_len;
   logic [ORDER_CW:0]      row_addr;
   logic [ORDER_CW:0]      adv_sum;

   assign load_run   = cmd.accept && (req_payload.op == OP_LOAD_RUN)
                       && (runs_loaded_ff < RUN_CW'(RUN_SLOTS));
   assign load_order = cmd.accept && (req_payload.op == OP_LOAD_ORDER)
                       && (orders_loaded_ff < ORDER_CW'(ORDER_SLOTS));

   assign len_clamped = (req_payload.run_length > LEN_W'(MAX_RUN)) ?
                        LEN_W'(MAX_RUN) : req_payload.run_length;

   assign run_val  = run_rdata_ff[KEY_W+LEN_W-1:LEN_W];
   assign run_len  = run_rdata_ff[LEN_W-1:0];
   assign row_addr = {1'b0, order_cursor_ff} + (ORDER_CW+1)'(row_idx_ff);
   assign adv_sum  = {1'b0, order_cursor_ff} + (ORDER_CW+1)'(run_len);

   always_comb begin
      runs_loaded_in   = runs_loaded_ff;
      orders_loaded_in = orders_loaded_ff;
      run_cursor_in    = run_cursor_ff;
      order_cursor_in  = order_cursor_ff;
      rsp_valid_in     = rsp_valid_ff;
      if (load_run) begin
         runs_loaded_in = runs_loaded_ff + RUN_CW'(1);
      end
      if (load_order) begin
         orders_loaded_in = orders_loaded_ff + ORDER_CW'(1);
      end
      if (cmd.finish_run) begin
         run_cursor_in = run_cursor_ff + RUN_CW'(1);
         if (adv_sum >= (ORDER_CW+1)'(ORDER_SLOTS)) begin
            order_cursor_in = ORDER_CW'(ORDER_SLOTS);
         end else begin
            order_cursor_in = adv_sum[ORDER_CW-1:0];
         end
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.row_emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         runs_loaded_ff   <= '0;
         orders_loaded_ff <= '0;
         run_cursor_ff    <= '0;
         order_cursor_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         runs_loaded_ff   <= runs_loaded_in;
         orders_loaded_ff <= orders_loaded_in;
         run_cursor_ff    <= run_cursor_in;
         order_cursor_ff  <= order_cursor_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_run) begin
         run_mem[runs_loaded_ff[RUN_AW-1:0]] <= {req_payload.key_value, len_clamped};
      end
      if (cmd.run_rd) begin
         run_rdata_ff <= run_mem[run_cursor_ff[RUN_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (load_order) begin
         order_mem[orders_loaded_ff[ORDER_AW-1:0]] <= req_payload.key_value;
      end
      if (cmd.row_rd) begin
         order_rdata_ff <= order_mem[row_addr[ORDER_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff     <= req_payload.key_value;
         row_idx_ff <= '0;
      end
      if (cmd.row_rd) begin
         in_range_ff <= (row_addr < (ORDER_CW+1)'(orders_loaded_ff));
      end
      if (cmd.row_next) begin
         row_idx_ff <= row_idx_ff + LEN_W'(1);
      end
      if (cmd.row_emit) begin
         rsp_ff.customer_key <= key_ff;
         rsp_ff.order_key    <= in_range_ff ? order_rdata_ff : '0;
         rsp_ff.last_row     <= status.row_last;
      end
   end

   always_comb begin
      status.runs_left = (run_cursor_ff < runs_loaded_ff);
      status.key_gt    = (key_ff > run_val);
      status.key_eq    = (key_ff == run_val);
      status.rl_zero   = (run_len == '0);
      status.row_last  = (LEN_W'(row_idx_ff + LEN_W'(1)) == run_len);
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hdl/rlemj_ctrl.sv
// ----------------------------------------------------------------------------
// rlemj_ctrl
// Sequencer: accepts transactions, walks runs and emits matched rows.
// ----------------------------------------------------------------------------
module rlemj_ctrl
   import rlemj_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  rlemj_status_type status,
   output rlemj_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_FETCH    = 3'd1;
   localparam logic [2:0] ST_COMPARE  = 3'd2;
   localparam logic [2:0] ST_ROW_READ = 3'd3;
   localparam logic [2:0] ST_ROW_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == OP_PROBE) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            if (status.runs_left) begin
               cmd.run_rd = 1'b1;
               state_in   = ST_COMPARE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_COMPARE: begin
            if (status.key_gt) begin
               cmd.finish_run = 1'b1;
               state_in       = ST_FETCH;
            end else if (status.key_eq && status.rl_zero) begin
               cmd.finish_run = 1'b1;
               state_in       = ST_IDLE;
            end else if (status.key_eq) begin
               state_in = ST_ROW_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ROW_READ: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_ROW_EMIT;
         end
         ST_ROW_EMIT: begin
            if (status.rsp_free) begin
               cmd.row_emit = 1'b1;
               if (status.row_last) begin
                  cmd.finish_run = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.row_next = 1'b1;
                  state_in     = ST_ROW_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/rle_merge_join_probe_top.sv
// ----------------------------------------------------------------------------
// rle_merge_join_probe_top
// Sort-merge join of ascending probe keys against a run-length encoded column.
// ----------------------------------------------------------------------------
// A load transaction (run or order key) leaves the block idle, ready again in
// the next cycle. A probe reads and compares each run (ST_FETCH, ST_COMPARE),
// ends in ST_FETCH at the end of the loaded runs, and reads and emits each row
// (ST_ROW_READ, ST_ROW_EMIT, which waits while rsp_ready is held low):
// the run store and the order-key store each have one registered read port,
// and each run compare and each row waits on one read. Results leave through
// an output register, so the next transaction is taken while the last row of
// a probe still waits on rsp_ready. No clearing pass after reset.
// ----------------------------------------------------------------------------
module rle_merge_join_probe_top
   import rlemj_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   rlemj_cmd_type    cmd;
   rlemj_status_type status;

   rlemj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_payload.op),
      .status    (status),
      .cmd       (cmd)
   );

   rlemj_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

### hdl/rlemj_checker.sv
// ----------------------------------------------------------------------------
// rlemj_checker
// Port-level checks of the RLE merge-join probe, bound to the top level.
// ----------------------------------------------------------------------------
module rlemj_checker
   import rlemj_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result transaction changed while stalled");

   a_probe_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_payload.op == OP_PROBE) |=> !req_ready)
      else $error("probe did not occupy the block");

   a_load_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_payload.op != OP_PROBE) |=> req_ready)
      else $error("load transaction took more than one cycle");

   a_rsp_from_probe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a probe in progress");

   a_idle_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && req_ready |=> !rsp_valid)
      else $error("result produced while idle");

endmodule

bind rle_merge_join_probe_top rlemj_checker u_rlemj_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
